// ----- hdl/fsmu_pkg.sv -----
// Shared types and constants for the first substring match unit.
`default_nettype none
package fsmu_pkg;

	localparam int PATTERN_MAX = 64;
	localparam int INDEX_BITS  = 16;
	localparam int LEN_BITS    = $clog2(PATTERN_MAX + 1);
	localparam int POS_W       = 16;
	localparam int OFS_W       = 16;
	// Wide enough to compare a text index against the offset and to hold offset plus one.
	localparam int CMP_W       = ((INDEX_BITS > OFS_W) ? INDEX_BITS : OFS_W) + 1;

	localparam logic [INDEX_BITS-1:0] INDEX_LIMIT = '1;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_PATTERN = 2'd1,
		OP_TEXT    = 2'd2,
		OP_END     = 2'd3
	} op_t;

	// Broadcast control from the sequencer to every cell of the chain.
	typedef struct packed {
		logic       clear;
		logic       load;
		logic       restart;
		logic       step;
		logic [7:0] data;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/first_substring_match_unit.sv -----
// Top level: sequencer, chain of compare cells and result register.
//
//  channel | direction | signals
//  in      | input     | in_valid, in_stall, operation, data_byte
//  out     | output    | out_valid, out_stall, found, match_position
//  cfg     | input     | cfg_wr_en, cfg_wr_data (start_offset)
//
// Every input beat is taken unless it is stalled; a text byte is compared in all cells at once.
// A result appears in the cycle after its end-of-text beat is accepted.
// The result register holds one beat; only an end-of-text beat is stalled while it is full
// and its result is not taken in the same cycle.
// Reset empties the pattern, clears the scan and sets start_offset to zero.
`default_nettype none
module first_substring_match_unit
	import fsmu_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        operation,
	input  wire logic [7:0]        data_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   found,
	output logic [POS_W-1:0]       match_position,
	input  wire logic              cfg_wr_en,
	input  wire logic [OFS_W-1:0]  cfg_wr_data
);

	logic [OFS_W-1:0]      start_offset_q;
	logic [LEN_BITS-1:0]   len_q;
	logic [INDEX_BITS-1:0] text_index_q;
	logic                  match_found_q;
	logic [INDEX_BITS-1:0] match_pos_q;
	logic                  out_valid_q;
	logic                  found_q;
	logic [POS_W-1:0]      position_q;

	op_t        op;
	logic       accept;
	logic       is_clear;
	logic       is_pattern;
	logic       is_text;
	logic       is_end;
	logic       start_ok;
	logic       hit_any;
	logic [CMP_W-1:0] empty_pos;
	logic [INDEX_BITS-1:0] hit_pos;
	cell_ctrl_t ctrl;

	logic [PATTERN_MAX-1:0] fill_w;
	logic [PATTERN_MAX-1:0] match_w;
	logic [PATTERN_MAX-1:0] hit_w;

	assign op       = op_t'(operation);
	assign in_stall = out_valid_q && out_stall && (op == OP_END);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		is_clear   = 1'b0;
		is_pattern = 1'b0;
		is_text    = 1'b0;
		is_end     = 1'b0;
		unique case (op)
			OP_CLEAR:   is_clear   = accept;
			OP_PATTERN: is_pattern = accept;
			OP_TEXT:    is_text    = accept;
			OP_END:     is_end     = accept;
			default:    is_clear   = 1'b0;
		endcase
	end

	// A new partial match may open only at or after the configured offset.
	assign start_ok = CMP_W'(text_index_q) >= CMP_W'(start_offset_q);

	always_comb begin
		ctrl.clear   = is_clear;
		ctrl.load    = is_pattern;
		ctrl.restart = is_clear || is_pattern || is_end;
		ctrl.step    = is_text && (text_index_q != INDEX_LIMIT) && !match_found_q
			&& (len_q != '0);
		ctrl.data    = data_byte;
	end

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic pf;
		logic nf;
		logic pm;
		if (k == 0) begin : g_first
			assign pf = 1'b1;
			assign pm = start_ok;
		end else begin : g_rest
			assign pf = fill_w[k-1];
			assign pm = match_w[k-1];
		end
		if (k == PATTERN_MAX - 1) begin : g_last
			assign nf = 1'b0;
		end else begin : g_mid
			assign nf = fill_w[k+1];
		end
		fsmu_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_fill  (pf),
			.next_fill  (nf),
			.prev_match (pm),
			.fill_q     (fill_w[k]),
			.match_q    (match_w[k]),
			.hit        (hit_w[k])
		);
	end

	assign hit_any = |hit_w;
	// One-based start of the match that ends at the current text index.
	assign hit_pos = text_index_q + INDEX_BITS'(2) - INDEX_BITS'(len_q);

	always_comb begin
		empty_pos = CMP_W'(start_offset_q) + CMP_W'(1);
		if (empty_pos > CMP_W'(INDEX_LIMIT)) begin
			empty_pos = CMP_W'(INDEX_LIMIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_offset_q <= '0;
		end else if (cfg_wr_en) begin
			start_offset_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q         <= '0;
			text_index_q  <= '0;
			match_found_q <= 1'b0;
			match_pos_q   <= '0;
			out_valid_q   <= 1'b0;
			found_q       <= 1'b0;
			position_q    <= '0;
		end else begin
			if (is_clear) begin
				len_q <= '0;
			end else if (is_pattern && (len_q < LEN_BITS'(PATTERN_MAX))) begin
				len_q <= len_q + LEN_BITS'(1);
			end

			if (ctrl.restart) begin
				text_index_q  <= '0;
				match_found_q <= 1'b0;
				match_pos_q   <= '0;
			end else if (is_text && (text_index_q != INDEX_LIMIT)) begin
				text_index_q <= text_index_q + INDEX_BITS'(1);
				if (ctrl.step && hit_any) begin
					match_found_q <= 1'b1;
					match_pos_q   <= hit_pos;
				end
			end

			if (is_end) begin
				out_valid_q <= 1'b1;
				if (len_q == '0) begin
					found_q    <= 1'b1;
					position_q <= POS_W'(empty_pos);
				end else if (match_found_q) begin
					found_q    <= 1'b1;
					position_q <= POS_W'(match_pos_q);
				end else begin
					found_q    <= 1'b0;
					position_q <= '0;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign match_position = position_q;

	// The fill flags form a prefix whose size is the pattern length.
	a_fill_len: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(fill_w) == int'(len_q))
		else $error("fill flags disagree with pattern length");

	a_found_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		match_found_q |-> (len_q != '0))
		else $error("match latched with empty pattern");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		is_clear |=> (len_q == '0) && (fill_w == '0) && !match_found_q)
		else $error("clear did not empty the pattern");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with empty result register");

	a_partial_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(is_pattern || is_end) |=> (match_w == '0) && (text_index_q == '0))
		else $error("scan not restarted");

endmodule
`default_nettype wire

// ----- hdl/fsmu_cell.sv -----
// One pattern place: stored byte, fill flag and partial match flag.
`default_nettype none
module fsmu_cell
	import fsmu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire logic       prev_fill,
	input  wire logic       next_fill,
	input  wire logic       prev_match,
	output logic            fill_q,
	output logic            match_q,
	output logic            hit
);

	logic [7:0] byte_q;
	logic       take;
	logic       match_next;

	// The first empty cell of the chain takes the next pattern byte.
	assign take       = ctrl.load && prev_fill && !fill_q;
	assign match_next = fill_q && prev_match && (byte_q == ctrl.data);
	// Only the last filled cell can complete a match.
	assign hit        = ctrl.step && match_next && !next_fill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				fill_q <= 1'b0;
			end else if (take) begin
				fill_q <= 1'b1;
			end
			if (ctrl.restart) begin
				match_q <= 1'b0;
			end else if (ctrl.step) begin
				match_q <= match_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= ctrl.data;
		end
	end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the first substring match unit, with its own search predictor.
`default_nettype none
module testbench
	import fsmu_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
	} search_report_t;

	// One directed row: either a register write (value is the offset) or a beat (value is the byte).
	typedef struct packed {
		logic             cfg;
		op_t              op;
		logic [15:0]      value;
		logic             typed;
		logic             found;
		logic [POS_W-1:0] pos;
	} plan_row_t;

	localparam int unsigned TEXT_END = int'(INDEX_LIMIT);

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        operation;
	logic [7:0]        data_byte;
	logic              out_valid;
	logic              out_stall;
	logic              found;
	logic [POS_W-1:0]  match_position;
	logic              cfg_wr_en;
	logic [OFS_W-1:0]  cfg_wr_data;

	// Predictor state.
	logic [7:0]             pat_mem [PATTERN_MAX];
	int unsigned            pat_len;
	int unsigned            txt_idx;
	logic [PATTERN_MAX-1:0] part_vec;
	bit                     hit;
	int unsigned            hit_start;
	logic [OFS_W-1:0]       offset_reg;

	search_report_t reports_due [$];
	int             err_count;
	int             beats_sent;
	int             ends_sent;
	int             idle_rate;
	int             hold_asked;

	plan_row_t plan [25] = '{
		'{1'b0, OP_END,     16'h0000, 1'b1, 1'b1, 16'd1},
		'{1'b1, OP_CLEAR,   16'hFFFF, 1'b0, 1'b0, 16'd0},
		'{1'b0, OP_END,     16'h0000, 1'b1, 1'b1, 16'hFFFF},
		'{1'b1, OP_CLEAR,   16'd3,    1'b0, 1'b0, 16'd0},
		'{1'b0, OP_PATTERN, 16'h00,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_PATTERN, 16'hFF,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_TEXT,    16'h00,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_TEXT,    16'hFF,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_TEXT,    16'h00,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_TEXT,    16'h00,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_TEXT,    16'hFF,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_TEXT,    16'h00,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_END,     16'h0000, 1'b1, 1'b1, 16'd4},
		'{1'b0, OP_TEXT,    16'h00,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_END,     16'h0000, 1'b1, 1'b0, 16'd0},
		'{1'b0, OP_CLEAR,   16'h00,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_END,     16'h0000, 1'b1, 1'b1, 16'd4},
		'{1'b1, OP_CLEAR,   16'd0,    1'b0, 1'b0, 16'd0},
		'{1'b0, OP_PATTERN, 16'hAA,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_PATTERN, 16'hAA,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_TEXT,    16'hAA,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_TEXT,    16'hAA,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_TEXT,    16'hAA,   1'b0, 1'b0, 16'd0},
		'{1'b0, OP_END,     16'h0000, 1'b1, 1'b1, 16'd1},
		'{1'b0, OP_END,     16'h0000, 1'b1, 1'b0, 16'd0}
	};

	first_substring_match_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.match_position (match_position),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		err_count++;
	endtask

	function automatic void restart_scan();
		txt_idx = 0;
		part_vec = '0;
		hit = 1'b0;
		hit_start = 0;
	endfunction

	// Advances the predicted search by one beat; an end-of-text beat yields a report.
	function automatic void scan_beat(input op_t op, input logic [7:0] b,
			output bit has_report, output search_report_t rep);
		bit prev;
		int unsigned pos;
		has_report = 1'b0;
		rep = '0;
		case (op)
			OP_CLEAR: begin
				pat_len = 0;
				restart_scan();
			end
			OP_PATTERN: begin
				if (pat_len < PATTERN_MAX) begin
					pat_mem[pat_len] = b;
					pat_len++;
				end
				restart_scan();
			end
			OP_TEXT: begin
				if (txt_idx < TEXT_END) begin
					if (!hit && pat_len > 0) begin
						// Walk from the top so each place sees the previous beat's vector.
						for (int k = pat_len - 1; k >= 0; k--) begin
							prev = (k == 0) ? (txt_idx >= offset_reg) : part_vec[k-1];
							part_vec[k] = prev && (pat_mem[k] == b);
						end
						if (part_vec[pat_len-1]) begin
							hit = 1'b1;
							hit_start = txt_idx + 1 - pat_len;
						end
					end
					txt_idx++;
				end
			end
			default: begin
				has_report = 1'b1;
				if (pat_len == 0) begin
					pos = int'(offset_reg) + 1;
					if (pos > TEXT_END)
						pos = TEXT_END;
					rep.found = 1'b1;
					rep.pos = pos[POS_W-1:0];
				end else if (hit) begin
					pos = hit_start + 1;
					rep.found = 1'b1;
					rep.pos = pos[POS_W-1:0];
				end
				restart_scan();
			end
		endcase
	endfunction

	task automatic offer_beat(input op_t op, input logic [7:0] b,
			input bit typed = 1'b0, input search_report_t want = '0);
		bit has_report;
		search_report_t rep;
		if (idle_rate != 0 && $urandom_range(idle_rate - 1, 0) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(17, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		beats_sent++;
		scan_beat(op, b, has_report, rep);
		if (has_report) begin
			ends_sent++;
			reports_due.push_back(typed ? want : rep);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (reports_due.size() != 0) @(posedge clk);
		// A text beat has no report, so let the pipe settle before returning.
		repeat (4) @(posedge clk);
	endtask

	task automatic set_offset(input logic [OFS_W-1:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		offset_reg = v;
	endtask

	// Clears (mostly), loads pattern bytes, then runs one to three scans that often hold them.
	task automatic search_phase();
		logic [7:0] alpha [4];
		logic [7:0] pat [$];
		logic [7:0] txt [$];
		logic [7:0] b;
		bit wide;
		int plen, tlen, span, at;
		wide = ($urandom_range(3, 0) == 0);
		foreach (alpha[i])
			alpha[i] = 8'($urandom_range(255, 0));
		case ($urandom_range(9, 0))
			0: plen = 0;
			1: plen = $urandom_range(70, 60);
			default: plen = $urandom_range(4, 1);
		endcase
		if ($urandom_range(3, 0) != 0)
			offer_beat(OP_CLEAR, 8'($urandom_range(255, 0)));
		repeat (plen) begin
			b = wide ? 8'($urandom_range(255, 0)) : alpha[$urandom_range(3, 0)];
			pat.push_back(b);
			offer_beat(OP_PATTERN, b);
		end
		span = (plen > PATTERN_MAX) ? PATTERN_MAX : plen;
		repeat ($urandom_range(3, 1)) begin
			txt.delete();
			tlen = $urandom_range(16, 0) + ((plen > 8) ? plen : 0);
			repeat (tlen) begin
				b = wide ? 8'($urandom_range(255, 0)) : alpha[$urandom_range(3, 0)];
				txt.push_back(b);
			end
			if (span > 0 && tlen >= span && $urandom_range(1, 0) == 1) begin
				at = $urandom_range(tlen - span, 0);
				for (int i = 0; i < span; i++)
					txt[at + i] = pat[i];
			end
			foreach (txt[i])
				offer_beat(OP_TEXT, txt[i]);
			offer_beat(OP_END, 8'($urandom_range(255, 0)));
		end
	endtask

	function automatic logic [OFS_W-1:0] pick_offset();
		case ($urandom_range(5, 0))
			0: return '0;
			1: return '1;
			2: return OFS_W'(1);
			3, 4: return OFS_W'($urandom_range(12, 0));
			default: return OFS_W'($urandom_range(65535, 0));
		endcase
	endfunction

	initial begin
		bit pressed;
		search_report_t want;
		err_count = 0;
		beats_sent = 0;
		ends_sent = 0;
		idle_rate = 0;
		hold_asked = 0;
		pressed = 1'b0;
		pat_len = 0;
		offset_reg = '0;
		restart_scan();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_CLEAR;
		data_byte <= 8'h00;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].cfg) begin
				set_offset(plan[i].value);
			end else begin
				want.found = plan[i].found;
				want.pos = plan[i].pos;
				offer_beat(plan[i].op, plan[i].value[7:0], plan[i].typed, want);
			end
		end

		while (beats_sent < 300 || ends_sent < 30) begin
			case ($urandom_range(2, 0))
				0: idle_rate = 0;
				1: idle_rate = 8;
				default: idle_rate = 3;
			endcase
			if (!pressed && beats_sent > 150) begin
				// Receiver holds off while end-of-text beats keep coming.
				pressed = 1'b1;
				hold_asked++;
				repeat (12) begin
					offer_beat(OP_TEXT, 8'($urandom_range(255, 0)));
					offer_beat(OP_END, 8'($urandom_range(255, 0)));
				end
			end
			case ($urandom_range(9, 0))
				0, 1: set_offset(pick_offset());
				2: repeat (6) offer_beat(op_t'($urandom_range(3, 0)),
					8'($urandom_range(255, 0)));
				default: search_phase();
			endcase
		end

		idle_rate = 0;
		set_offset(pick_offset());
		repeat (4) search_phase();

		wait_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Result side: checks each accepted beat and drives out_stall for the next edge.
	initial begin
		int stall_left;
		int hold_seen;
		search_report_t exp_rep;
		stall_left = 0;
		hold_seen = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					flag_error($sformatf("report with none due: found %0b position %0d",
						found, match_position));
				end else begin
					exp_rep = reports_due.pop_front();
					if (found !== exp_rep.found)
						flag_error($sformatf("found is %0b, expected %0b",
							found, exp_rep.found));
					if (match_position !== exp_rep.pos)
						flag_error($sformatf("match_position is %0d, expected %0d",
							match_position, exp_rep.pos));
				end
			end
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				stall_left = 200;
			end else if (stall_left == 0 && idle_rate != 0
					&& $urandom_range(idle_rate - 1, 0) == 0) begin
				stall_left = $urandom_range(17, 1);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#20ms;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
